/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, a, c)
`define ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* sv/i2cm_pkg.sv */
// types and constants of the i2c master byte transfer block
// used by i2cm_seq and i2c_master_byte_transfer
package i2cm_pkg;

	localparam int unsigned TimeoutW = 16;
	localparam logic [TimeoutW-1:0] TimeoutRst = 16'd2000;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_WR   = 2'd1,
		KIND_RD   = 2'd2,
		KIND_DATA = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST1     = 5'd1,
		PH_ST2     = 5'd2,
		PH_A_LOW   = 5'd3,
		PH_A_HIGH  = 5'd4,
		PH_A_ACKL  = 5'd5,
		PH_A_ACKH  = 5'd6,
		PH_A_WAIT  = 5'd7,
		PH_D_LOW   = 5'd8,
		PH_D_HIGH  = 5'd9,
		PH_D_ACKL  = 5'd10,
		PH_D_ACKH  = 5'd11,
		PH_D_WAIT  = 5'd12,
		PH_NEED    = 5'd13,
		PH_R_LOW   = 5'd14,
		PH_R_HIGH  = 5'd15,
		PH_RA_LOW  = 5'd16,
		PH_RA_HIGH = 5'd17,
		PH_RA_DONE = 5'd18,
		PH_SP_A    = 5'd19,
		PH_SP_B    = 5'd20,
		PH_SP_C    = 5'd21,
		PH_EP_A    = 5'd22,
		PH_EP_B    = 5'd23,
		PH_EP_C    = 5'd24
	} phase_t;

	typedef struct packed {
		logic       error;
		logic       done_res;
		logic       busy_res;
		logic       need_data;
		logic       rx_last;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       sda_level;
		logic       scl_level;
	} res_t;

endpackage

/* sv/i2cm_seq.sv */
// bus sequencer: phase register, shifter, counters and the timeout register
// depends on i2cm_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2cm_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  i2cm_pkg::kind_t                kind,
	input  logic [6:0]                     dev_addr,
	input  logic [7:0]                     reg_cmd,
	input  logic [7:0]                     data_byte,
	input  logic [7:0]                     length,
	input  logic                           sda_sample,
	input  logic                           cfg_we,
	input  logic [i2cm_pkg::TimeoutW-1:0]  cfg_wdata,
	output i2cm_pkg::res_t                 res
);

	i2cm_pkg::phase_t phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [i2cm_pkg::TimeoutW-1:0] wait_q, wait_d;
	logic [i2cm_pkg::TimeoutW-1:0] timeout_q;
	logic        read_mode_q, read_mode_d;
	logic [7:0]  pending_q, pending_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ack_seen, ack_tmo, bit_last;
	logic        rx_valid, rx_last, done, err;
	logic [7:0]  rx_byte;

	// acknowledge check and end of byte
	always_comb begin
		ack_seen = !sda_sample;
		ack_tmo  = sda_sample && (wait_q >= timeout_q);
		bit_last = bit_count_q >= 4'd7;
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (kind)
			i2cm_pkg::KIND_WR, i2cm_pkg::KIND_RD: begin
				if (phase_q == i2cm_pkg::PH_IDLE) phase_d = i2cm_pkg::PH_ST1;
			end
			i2cm_pkg::KIND_DATA: begin
				if (phase_q == i2cm_pkg::PH_NEED) phase_d = i2cm_pkg::PH_D_LOW;
			end
			i2cm_pkg::KIND_TICK: begin
				unique case (phase_q)
					i2cm_pkg::PH_IDLE:   phase_d = i2cm_pkg::PH_IDLE;
					i2cm_pkg::PH_ST1:    phase_d = i2cm_pkg::PH_ST2;
					i2cm_pkg::PH_ST2:    phase_d = i2cm_pkg::PH_A_LOW;
					i2cm_pkg::PH_A_LOW:  phase_d = i2cm_pkg::PH_A_HIGH;
					i2cm_pkg::PH_D_LOW:  phase_d = i2cm_pkg::PH_D_HIGH;
					i2cm_pkg::PH_A_HIGH: begin
						phase_d = bit_last ? i2cm_pkg::PH_A_ACKL : i2cm_pkg::PH_A_LOW;
					end
					i2cm_pkg::PH_D_HIGH: begin
						phase_d = bit_last ? i2cm_pkg::PH_D_ACKL : i2cm_pkg::PH_D_LOW;
					end
					i2cm_pkg::PH_A_ACKL: phase_d = i2cm_pkg::PH_A_ACKH;
					i2cm_pkg::PH_D_ACKL: phase_d = i2cm_pkg::PH_D_ACKH;
					i2cm_pkg::PH_A_ACKH: phase_d = i2cm_pkg::PH_A_WAIT;
					i2cm_pkg::PH_D_ACKH: phase_d = i2cm_pkg::PH_D_WAIT;
					i2cm_pkg::PH_A_WAIT: begin
						if (ack_seen) begin
							if (!read_mode_q) phase_d = i2cm_pkg::PH_D_LOW;
							else if (bytes_left_q == 8'd0) phase_d = i2cm_pkg::PH_SP_A;
							else phase_d = i2cm_pkg::PH_R_LOW;
						end else if (ack_tmo) begin
							phase_d = i2cm_pkg::PH_EP_A;
						end
					end
					i2cm_pkg::PH_D_WAIT: begin
						if (ack_seen || ack_tmo) begin
							phase_d = (bytes_left_q == 8'd0) ? i2cm_pkg::PH_SP_A
								: i2cm_pkg::PH_NEED;
						end
					end
					i2cm_pkg::PH_NEED:   phase_d = i2cm_pkg::PH_NEED;
					i2cm_pkg::PH_R_LOW:  phase_d = i2cm_pkg::PH_R_HIGH;
					i2cm_pkg::PH_R_HIGH: begin
						phase_d = bit_last ? i2cm_pkg::PH_RA_LOW : i2cm_pkg::PH_R_LOW;
					end
					i2cm_pkg::PH_RA_LOW:  phase_d = i2cm_pkg::PH_RA_HIGH;
					i2cm_pkg::PH_RA_HIGH: phase_d = i2cm_pkg::PH_RA_DONE;
					i2cm_pkg::PH_RA_DONE: begin
						phase_d = (bytes_left_q == 8'd0) ? i2cm_pkg::PH_SP_A
							: i2cm_pkg::PH_R_LOW;
					end
					i2cm_pkg::PH_SP_A: phase_d = i2cm_pkg::PH_SP_B;
					i2cm_pkg::PH_SP_B: phase_d = i2cm_pkg::PH_SP_C;
					i2cm_pkg::PH_SP_C: phase_d = i2cm_pkg::PH_IDLE;
					i2cm_pkg::PH_EP_A: phase_d = i2cm_pkg::PH_EP_B;
					i2cm_pkg::PH_EP_B: phase_d = i2cm_pkg::PH_EP_C;
					i2cm_pkg::PH_EP_C: phase_d = i2cm_pkg::PH_IDLE;
					default:           phase_d = i2cm_pkg::PH_IDLE;
				endcase
			end
			default: phase_d = phase_q;
		endcase
	end

	// datapath and line outputs
	always_comb begin
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		bytes_left_d = bytes_left_q;
		wait_d       = wait_q;
		read_mode_d  = read_mode_q;
		pending_d    = pending_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		rx_valid     = 1'b0;
		rx_last      = 1'b0;
		rx_byte      = 8'd0;
		done         = 1'b0;
		err          = 1'b0;
		unique case (kind)
			i2cm_pkg::KIND_WR, i2cm_pkg::KIND_RD: begin
				if (phase_q == i2cm_pkg::PH_IDLE) begin
					read_mode_d  = (kind == i2cm_pkg::KIND_RD);
					shift_d      = {dev_addr, kind == i2cm_pkg::KIND_RD};
					bytes_left_d = length;
					pending_d    = reg_cmd;
					bit_count_d  = 4'd0;
					wait_d       = '0;
					scl_d        = 1'b1;
					sda_d        = 1'b1;
				end
			end
			i2cm_pkg::KIND_DATA: begin
				if (phase_q == i2cm_pkg::PH_NEED) begin
					shift_d      = data_byte;
					bytes_left_d = bytes_left_q - 8'd1;
					bit_count_d  = 4'd0;
				end
			end
			i2cm_pkg::KIND_TICK: begin
				unique case (phase_q)
					i2cm_pkg::PH_IDLE, i2cm_pkg::PH_NEED: begin
					end
					i2cm_pkg::PH_ST1: sda_d = 1'b0;
					i2cm_pkg::PH_ST2: scl_d = 1'b0;
					i2cm_pkg::PH_A_LOW, i2cm_pkg::PH_D_LOW: begin
						scl_d = 1'b0;
						sda_d = shift_q[7];
					end
					i2cm_pkg::PH_A_HIGH, i2cm_pkg::PH_D_HIGH: begin
						scl_d       = 1'b1;
						shift_d     = {shift_q[6:0], 1'b0};
						bit_count_d = bit_count_q + 4'd1;
					end
					i2cm_pkg::PH_A_ACKL, i2cm_pkg::PH_D_ACKL: begin
						scl_d = 1'b0;
						sda_d = 1'b1;
					end
					i2cm_pkg::PH_A_ACKH, i2cm_pkg::PH_D_ACKH: begin
						scl_d  = 1'b1;
						wait_d = '0;
					end
					i2cm_pkg::PH_A_WAIT: begin
						if (ack_seen) begin
							scl_d       = 1'b0;
							bit_count_d = 4'd0;
							if (!read_mode_q) shift_d = pending_q;
						end else if (ack_tmo) begin
							scl_d = 1'b0;
						end else begin
							wait_d = wait_q + 16'd1;
						end
					end
					i2cm_pkg::PH_D_WAIT: begin
						if (ack_seen || ack_tmo) scl_d = 1'b0;
						else wait_d = wait_q + 16'd1;
					end
					i2cm_pkg::PH_R_LOW: begin
						scl_d = 1'b0;
						sda_d = 1'b1;
					end
					i2cm_pkg::PH_R_HIGH: begin
						scl_d       = 1'b1;
						shift_d     = {shift_q[6:0], sda_sample};
						bit_count_d = bit_count_q + 4'd1;
						if (bit_last) begin
							rx_valid = 1'b1;
							rx_byte  = {shift_q[6:0], sda_sample};
							rx_last  = bytes_left_q <= 8'd1;
						end
					end
					i2cm_pkg::PH_RA_LOW: begin
						scl_d = 1'b0;
						sda_d = bytes_left_q <= 8'd1;
					end
					i2cm_pkg::PH_RA_HIGH: begin
						scl_d = 1'b1;
						if (bytes_left_q != 8'd0) bytes_left_d = bytes_left_q - 8'd1;
					end
					i2cm_pkg::PH_RA_DONE: begin
						scl_d       = 1'b0;
						bit_count_d = 4'd0;
					end
					i2cm_pkg::PH_SP_A, i2cm_pkg::PH_EP_A: begin
						scl_d = 1'b0;
						sda_d = 1'b0;
					end
					i2cm_pkg::PH_SP_B, i2cm_pkg::PH_EP_B: scl_d = 1'b1;
					i2cm_pkg::PH_SP_C, i2cm_pkg::PH_EP_C: begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						done  = 1'b1;
						err   = (phase_q == i2cm_pkg::PH_EP_C);
					end
					default: begin
						scl_d = 1'b1;
						sda_d = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.scl_level = scl_d;
		res.sda_level = sda_d;
		res.rx_byte   = rx_byte;
		res.rx_valid  = rx_valid;
		res.rx_last   = rx_last;
		res.need_data = (phase_d == i2cm_pkg::PH_NEED);
		res.busy_res  = (phase_d != i2cm_pkg::PH_IDLE);
		res.done_res  = done;
		res.error     = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cm_pkg::PH_IDLE;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			bytes_left_q <= 8'd0;
			wait_q       <= '0;
			read_mode_q  <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			bytes_left_q <= bytes_left_d;
			wait_q       <= wait_d;
			read_mode_q  <= read_mode_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) pending_q <= pending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= i2cm_pkg::TimeoutRst;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	`ASSERT_IMP(a_bit_count_range, clk, arst_n, 1'b1, bit_count_q <= 4'd8)
	`ASSERT_IMP(a_idle_lines_released, clk, arst_n, phase_q == i2cm_pkg::PH_IDLE, scl_q && sda_q)
	`ASSERT_IMP(a_rx_only_in_read, clk, arst_n, step && rx_valid, read_mode_q)

endmodule

/* sv/i2c_master_byte_transfer.sv */
// Seven-bit I2C master sequencer stepped by tick requests, one half-bit per tick,
// with write data fetched on need_data and read bytes returned on rx_valid.
// Every accepted request gives exactly one result request, which appears on the
// master side in the cycle after acceptance unless an earlier result still waits
// on m_tready. The sequencer state updates in one pass of logic, so a new request
// is taken in every cycle while s_tready is high; a skid entry behind the output
// register keeps s_tready high while one result waits, and s_tready drops only
// while both hold a result. Depends on i2cm_pkg, i2cm_seq, assert_macros.svh.
`include "assert_macros.svh"

module i2c_master_byte_transfer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// dev_addr[6:0], reg_cmd[14:7], data_byte[22:15], length[30:23], sda_sample[31]
	input  logic [31:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_level[1], rx_byte[9:2], rx_valid[10], need_data[11],
	// busy_res[12], done_res[13], error[14], zero[15]
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	i2cm_pkg::res_t res_new, out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic in_acc;
	i2cm_pkg::kind_t kind;

	assign s_tready = !skid_valid_q;
	assign in_acc   = s_tvalid && s_tready;
	assign kind     = i2cm_pkg::kind_t'(s_tuser);

	i2cm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_acc),
		.kind       (kind),
		.dev_addr   (s_tdata[6:0]),
		.reg_cmd    (s_tdata[14:7]),
		.data_byte  (s_tdata[22:15]),
		.length     (s_tdata[30:23]),
		.sda_sample (s_tdata[31]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res        (res_new)
	);

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_acc) out_q <= res_new;
		end else if (in_acc) begin
			skid_q <= res_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.rx_last;
	assign m_tdata  = {1'b0, out_q.error, out_q.done_res, out_q.busy_res, out_q.need_data,
		out_q.rx_valid, out_q.rx_byte, out_q.sda_level, out_q.scl_level};

	`ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_NXT(a_request_gives_result, clk, arst_n, in_acc, m_tvalid)
	`ASSERT_IMP(a_error_with_done, clk, arst_n, m_tvalid && out_q.error, out_q.done_res)
	`ASSERT_IMP(a_need_while_busy, clk, arst_n, m_tvalid && out_q.need_data, out_q.busy_res)

endmodule

/* verif/i2c_master_byte_transfer_test.sv */
// self-checking testbench for i2c_master_byte_transfer: streams tick, request and data
// requests, predicts every result with a local sequencer model and compares in order
// depends on i2cm_pkg and the i2c_master_byte_transfer rtl
`timescale 1ns / 100ps

module i2c_master_byte_transfer_test;
	import i2cm_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] addr;
		logic [7:0] cmd;
		logic [7:0] dat;
		logic [7:0] len;
		logic       sda;
	} bus_req_t;

	typedef enum logic [1:0] {
		ACK_PENDING,
		ACK_SEEN,
		ACK_LATE
	} ack_t;

	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned ReportLimit = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	bus_req_t tx_req_q[$];
	res_t     bus_expect_q[$];

	// sequencer model state
	phase_t      seq_phase;
	logic [3:0]  bit_cnt;
	logic [7:0]  shifter;
	logic [7:0]  bytes_rem;
	logic [15:0] ack_wait;
	logic        rd_mode;
	logic [7:0]  cmd_byte;
	logic        scl_q;
	logic        sda_q;
	logic [15:0] timeout_ticks;

	int unsigned active_items = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles = 0;
	logic        no_idle = 1'b0;
	logic [3:0]  tx_gap = '0;
	logic [3:0]  tx_draw;
	logic [3:0]  rx_stall = '0;
	logic [3:0]  rx_draw;
	res_t        got;
	res_t        want;

	i2c_master_byte_transfer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [3:0] draw_idle();
		if (no_idle)
			return 4'd0;
		return 4'($urandom_range(0, 9));
	endfunction

	function automatic ack_t ack_poll(input logic sda);
		if (!sda)
			return ACK_SEEN;
		if (ack_wait >= timeout_ticks)
			return ACK_LATE;
		ack_wait = ack_wait + 16'd1;
		return ACK_PENDING;
	endfunction

	task automatic reset_bus_model();
		timeout_ticks = TimeoutRst;
		seq_phase = PH_IDLE;
		bit_cnt = '0;
		shifter = '0;
		bytes_rem = '0;
		ack_wait = '0;
		rd_mode = 1'b0;
		cmd_byte = '0;
		scl_q = 1'b1;
		sda_q = 1'b1;
	endtask

	task automatic predict_bus_step(input bus_req_t req);
		res_t nxt;
		ack_t ack;
		nxt = '0;
		case (req.kind)
			KIND_WR, KIND_RD: begin
				if (seq_phase == PH_IDLE) begin
					rd_mode = (req.kind == KIND_RD);
					shifter = {req.addr, rd_mode};
					bytes_rem = req.len;
					cmd_byte = req.cmd;
					bit_cnt = '0;
					ack_wait = '0;
					scl_q = 1'b1;
					sda_q = 1'b1;
					seq_phase = PH_ST1;
				end
			end
			KIND_DATA: begin
				if (seq_phase == PH_NEED) begin
					shifter = req.dat;
					bytes_rem = bytes_rem - 8'd1;
					bit_cnt = '0;
					seq_phase = PH_D_LOW;
				end
			end
			default: begin
				case (seq_phase)
					PH_IDLE: ;
					PH_ST1: begin
						sda_q = 1'b0;
						seq_phase = PH_ST2;
					end
					PH_ST2: begin
						scl_q = 1'b0;
						seq_phase = PH_A_LOW;
					end
					PH_A_LOW, PH_D_LOW: begin
						scl_q = 1'b0;
						sda_q = shifter[7];
						seq_phase = (seq_phase == PH_A_LOW) ? PH_A_HIGH : PH_D_HIGH;
					end
					PH_A_HIGH, PH_D_HIGH: begin
						scl_q = 1'b1;
						shifter = {shifter[6:0], 1'b0};
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt >= 4'd8)
							seq_phase = (seq_phase == PH_A_HIGH) ? PH_A_ACKL : PH_D_ACKL;
						else
							seq_phase = (seq_phase == PH_A_HIGH) ? PH_A_LOW : PH_D_LOW;
					end
					PH_A_ACKL, PH_D_ACKL: begin
						scl_q = 1'b0;
						sda_q = 1'b1;
						seq_phase = (seq_phase == PH_A_ACKL) ? PH_A_ACKH : PH_D_ACKH;
					end
					PH_A_ACKH, PH_D_ACKH: begin
						scl_q = 1'b1;
						ack_wait = '0;
						seq_phase = (seq_phase == PH_A_ACKH) ? PH_A_WAIT : PH_D_WAIT;
					end
					PH_A_WAIT: begin
						ack = ack_poll(req.sda);
						if (ack == ACK_SEEN) begin
							scl_q = 1'b0;
							bit_cnt = '0;
							if (rd_mode) begin
								seq_phase = (bytes_rem == 8'd0) ? PH_SP_A : PH_R_LOW;
							end else begin
								shifter = cmd_byte;
								seq_phase = PH_D_LOW;
							end
						end else if (ack == ACK_LATE) begin
							scl_q = 1'b0;
							seq_phase = PH_EP_A;
						end
					end
					PH_D_WAIT: begin
						ack = ack_poll(req.sda);
						if (ack != ACK_PENDING) begin
							scl_q = 1'b0;
							seq_phase = (bytes_rem == 8'd0) ? PH_SP_A : PH_NEED;
						end
					end
					PH_NEED: ;
					PH_R_LOW: begin
						scl_q = 1'b0;
						sda_q = 1'b1;
						seq_phase = PH_R_HIGH;
					end
					PH_R_HIGH: begin
						scl_q = 1'b1;
						shifter = {shifter[6:0], req.sda};
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt >= 4'd8) begin
							nxt.rx_valid = 1'b1;
							nxt.rx_byte = shifter;
							nxt.rx_last = (bytes_rem <= 8'd1);
							seq_phase = PH_RA_LOW;
						end else begin
							seq_phase = PH_R_LOW;
						end
					end
					PH_RA_LOW: begin
						scl_q = 1'b0;
						sda_q = (bytes_rem <= 8'd1);
						seq_phase = PH_RA_HIGH;
					end
					PH_RA_HIGH: begin
						scl_q = 1'b1;
						if (bytes_rem != 8'd0)
							bytes_rem = bytes_rem - 8'd1;
						seq_phase = PH_RA_DONE;
					end
					PH_RA_DONE: begin
						scl_q = 1'b0;
						bit_cnt = '0;
						seq_phase = (bytes_rem == 8'd0) ? PH_SP_A : PH_R_LOW;
					end
					PH_SP_A, PH_EP_A: begin
						scl_q = 1'b0;
						sda_q = 1'b0;
						seq_phase = (seq_phase == PH_SP_A) ? PH_SP_B : PH_EP_B;
					end
					PH_SP_B, PH_EP_B: begin
						scl_q = 1'b1;
						seq_phase = (seq_phase == PH_SP_B) ? PH_SP_C : PH_EP_C;
					end
					PH_SP_C, PH_EP_C: begin
						sda_q = 1'b1;
						scl_q = 1'b1;
						nxt.done_res = 1'b1;
						nxt.error = (seq_phase == PH_EP_C);
						seq_phase = PH_IDLE;
					end
					default: begin
						scl_q = 1'b1;
						sda_q = 1'b1;
						seq_phase = PH_IDLE;
					end
				endcase
			end
		endcase
		nxt.scl_level = scl_q;
		nxt.sda_level = sda_q;
		nxt.need_data = (seq_phase == PH_NEED);
		nxt.busy_res = (seq_phase != PH_IDLE);
		bus_expect_q.push_back(nxt);
	endtask

	task automatic queue_request(input kind_t kind, input logic [6:0] addr,
			input logic [7:0] cmd, input logic [7:0] dat, input logic [7:0] len,
			input logic sda);
		bus_req_t req;
		req = '{kind: kind, addr: addr, cmd: cmd, dat: dat, len: len, sda: sda};
		if ((kind == KIND_TICK && seq_phase != PH_IDLE) ||
				((kind == KIND_WR || kind == KIND_RD) && seq_phase == PH_IDLE) ||
				(kind == KIND_DATA && seq_phase == PH_NEED))
			active_items++;
		predict_bus_step(req);
		tx_req_q.push_back(req);
	endtask

	task automatic queue_noise();
		queue_request(kind_t'($urandom_range(0, 3)), 7'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic queue_tick(input logic sda);
		queue_request(KIND_TICK, 7'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), sda);
	endtask

	// run the current transfer to its stop, ack_pct is the chance of an ack per wait tick
	task automatic clock_until_idle(input int unsigned ack_pct, input int unsigned noise_pct);
		while (seq_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct)
				queue_noise();
			else if (seq_phase == PH_NEED)
				queue_request(KIND_DATA, 7'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			else if (seq_phase == PH_A_WAIT || seq_phase == PH_D_WAIT)
				queue_tick($urandom_range(0, 99) >= ack_pct);
			else
				queue_tick(1'($urandom));
		end
	endtask

	task automatic drain();
		while (tx_req_q.size() != 0 || bus_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] ticks);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_ticks = ticks;
	endtask

	task automatic random_phase(input int unsigned target, input logic allow_nack);
		int unsigned start;
		logic        paused;
		logic [7:0]  len;
		int unsigned ack_pct;
		start = active_items;
		paused = 1'b0;
		while (active_items - start < target) begin
			if (!paused && active_items - start >= target / 2) begin
				// hold the sender until every result is back
				drain();
				paused = 1'b1;
			end
			if (seq_phase != PH_IDLE) begin
				clock_until_idle(80, 5);
			end else if ($urandom_range(0, 9) == 0) begin
				queue_noise();
			end else if ($urandom_range(0, 9) == 0) begin
				queue_tick(1'($urandom));
			end else begin
				len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 8))
					: 8'($urandom_range(0, 4));
				queue_request($urandom_range(0, 1) ? KIND_RD : KIND_WR, 7'($urandom),
					8'($urandom), 8'($urandom), len, 1'($urandom));
				ack_pct = (allow_nack && $urandom_range(0, 4) == 0) ? 0
					: $urandom_range(60, 100);
				clock_until_idle(ack_pct, 5);
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap <= '0;
		end else if (s_tvalid && s_tready) begin
			tx_req_q.delete(0);
			tx_draw = draw_idle();
			if (tx_draw == 4'd0 && tx_req_q.size() != 0) begin
				s_tdata <= {tx_req_q[0].sda, tx_req_q[0].len, tx_req_q[0].dat,
					tx_req_q[0].cmd, tx_req_q[0].addr};
				s_tuser <= tx_req_q[0].kind;
			end else begin
				s_tvalid <= 1'b0;
				tx_gap <= (tx_draw != 4'd0) ? tx_draw - 4'd1 : 4'd0;
			end
		end else if (!s_tvalid) begin
			if (tx_gap != 4'd0) begin
				tx_gap <= tx_gap - 4'd1;
			end else if (tx_req_q.size() != 0) begin
				s_tdata <= {tx_req_q[0].sda, tx_req_q[0].len, tx_req_q[0].dat,
					tx_req_q[0].cmd, tx_req_q[0].addr};
				s_tuser <= tx_req_q[0].kind;
				s_tvalid <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= '0;
		end else if (m_tvalid && m_tready) begin
			results_seen++;
			got.scl_level = m_tdata[0];
			got.sda_level = m_tdata[1];
			got.rx_byte = m_tdata[9:2];
			got.rx_valid = m_tdata[10];
			got.need_data = m_tdata[11];
			got.busy_res = m_tdata[12];
			got.done_res = m_tdata[13];
			got.error = m_tdata[14];
			got.rx_last = m_tlast;
			if (bus_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("result %0d arrived with nothing expected: tdata %h",
						results_seen, m_tdata);
			end else begin
				want = bus_expect_q.pop_front();
				if (got !== want || m_tdata[15] !== 1'b0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display({"result %0d mismatch: ",
							"scl/sda %b%b rx %h v%b l%b need %b busy %b done %b err %b",
							" expected, scl/sda %b%b rx %h v%b l%b need %b busy %b",
							" done %b err %b pad %b seen"}, results_seen,
							want.scl_level, want.sda_level, want.rx_byte,
							want.rx_valid, want.rx_last, want.need_data,
							want.busy_res, want.done_res, want.error,
							got.scl_level, got.sda_level, got.rx_byte,
							got.rx_valid, got.rx_last, got.need_data,
							got.busy_res, got.done_res, got.error, m_tdata[15]);
				end
			end
			rx_draw = draw_idle();
			if (rx_draw != 4'd0) begin
				m_tready <= 1'b0;
				rx_stall <= rx_draw - 4'd1;
			end
		end else if (!m_tready) begin
			if (rx_stall != 4'd0)
				rx_stall <= rx_stall - 4'd1;
			else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		reset_bus_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the timeout
		random_phase(20, 1'b0);

		// timeout zero: the first high sample at the address acknowledge aborts
		write_timeout(16'd0);
		queue_tick(1'b1);
		queue_request(KIND_DATA, 7'h00, 8'h00, 8'hA5, 8'h00, 1'b0);
		queue_request(KIND_WR, 7'h7F, 8'hFF, 8'h00, 8'hFF, 1'b0);
		queue_request(KIND_RD, 7'h00, 8'h00, 8'h00, 8'h01, 1'b1);
		queue_request(KIND_DATA, 7'h00, 8'h00, 8'hFF, 8'h00, 1'b1);
		clock_until_idle(0, 0);
		queue_request(KIND_RD, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		clock_until_idle(100, 0);
		queue_request(KIND_WR, 7'h2A, 8'h00, 8'h00, 8'h00, 1'b0);
		clock_until_idle(100, 0);
		queue_request(KIND_WR, 7'h55, 8'h81, 8'h00, 8'h01, 1'b1);
		clock_until_idle(100, 0);
		queue_request(KIND_WR, 7'h01, 8'h3C, 8'h00, 8'h02, 1'b0);
		clock_until_idle(0, 0);

		write_timeout(16'd1);
		queue_request(KIND_WR, 7'h33, 8'h7E, 8'h00, 8'h02, 1'b0);
		clock_until_idle(100, 0);
		queue_request(KIND_RD, 7'h7F, 8'hFF, 8'h00, 8'h02, 1'b0);
		clock_until_idle(100, 0);
		queue_request(KIND_RD, 7'h12, 8'h00, 8'h00, 8'h80, 1'b0);
		clock_until_idle(0, 0);
		random_phase(40, 1'b1);

		write_timeout(16'd3);
		no_idle = 1'b1;
		random_phase(30, 1'b1);
		no_idle = 1'b0;

		// widest timeout value
		write_timeout(16'hFFFF);
		no_idle = 1'b1;
		queue_request(KIND_RD, 7'($urandom), 8'($urandom), 8'h00, 8'h01, 1'b0);
		clock_until_idle(100, 0);
		random_phase(10, 1'b0);
		no_idle = 1'b0;

		write_timeout(16'($urandom_range(4, 40)));
		random_phase(40, 1'b1);

		write_timeout(16'd2000);
		random_phase(20, 1'b0);

		drain();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && bus_expect_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
